// File: rtl/tfm_pkg.sv
// Shared types and constants for the Tenengrad focus measure unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tfm_pkg;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 12;
    localparam int THR_W      = 21;
    localparam int TOT_W      = 24;
    localparam int OUT_CNT_W  = 23;
    localparam int FRAC_W     = 17;
    localparam int IDX_W      = 8;
    localparam int CFG_DATA_W = 21;
    localparam int FIFO_DEPTH = 4;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam logic [DIM_W-1:0] MIN_DIM       = 12'd3;
    localparam logic [DIM_W-1:0] RST_WIDTH     = 12'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT    = 12'd480;
    localparam logic [THR_W-1:0] RST_THRESHOLD = 21'd500;
    localparam logic             RST_COLOR     = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_WIDTH     = 8'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 8'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 8'd2;
    localparam logic [IDX_W-1:0] REG_COLOR     = 8'd3;

    // Rounded BT.601 weights in Q14.
    localparam logic [10:0] W_BLUE  = 11'd1868;
    localparam logic [13:0] W_GREEN = 14'd9617;
    localparam logic [12:0] W_RED   = 13'd4899;
    localparam logic [21:0] W_ROUND = 22'd8192;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [THR_W-1:0] threshold;
        logic [TOT_W-1:0] total;
        logic             color;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] bot;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] top;
    } t_column;

endpackage

`default_nettype wire

// File: rtl/tfm_front.sv
// Front end: accepts pixels and converts them to 8-bit gray.
// Depends on tfm_pkg.
`default_nettype none

module tfm_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire tfm_pkg::t_cfg             i_cfg,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [tfm_pkg::PIX_W-1:0] i_blue,
    input  wire logic [tfm_pkg::PIX_W-1:0] i_green,
    input  wire logic [tfm_pkg::PIX_W-1:0] i_red,
    output logic                           o_gray_valid,
    input  wire logic                      i_gray_ready,
    output logic [tfm_pkg::PIX_W-1:0]      o_gray
);

    logic                      r_valid;
    logic [tfm_pkg::PIX_W-1:0] r_gray;
    logic [21:0]               sum;
    logic [tfm_pkg::PIX_W-1:0] gray;

    assign sum = 22'(i_blue * tfm_pkg::W_BLUE) + 22'(i_green * tfm_pkg::W_GREEN)
               + 22'(i_red * tfm_pkg::W_RED) + tfm_pkg::W_ROUND;
    assign gray = i_cfg.color ? sum[21:14] : i_green;

    assign o_in_ready   = !r_valid || i_gray_ready;
    assign o_gray_valid = r_valid;
    assign o_gray       = r_gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_gray_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_gray <= gray;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tfm_fifo.sv
// Short queue of gray pixels between the front end and the filter back end.
// Depends on tfm_pkg.
`default_nettype none

module tfm_fifo (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push_valid,
    output logic                           o_push_ready,
    input  wire logic [tfm_pkg::PIX_W-1:0] i_push_data,
    output logic                           o_pop_valid,
    input  wire logic                      i_pop_ready,
    output logic [tfm_pkg::PIX_W-1:0]      o_pop_data
);

    localparam int PW = $clog2(tfm_pkg::FIFO_DEPTH);

    logic [tfm_pkg::PIX_W-1:0] r_data [tfm_pkg::FIFO_DEPTH];
    logic [PW-1:0]             r_wr_ptr;
    logic [PW-1:0]             r_rd_ptr;
    logic [PW:0]               r_fill;
    logic                      push;
    logic                      pop;

    assign o_push_ready = r_fill != (PW+1)'(tfm_pkg::FIFO_DEPTH);
    assign o_pop_valid  = r_fill != '0;
    assign o_pop_data   = r_data[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tfm_back.sv
// Back end: line stores, 3x3 Sobel window, threshold count, last-row sweep
// and the serial divider for the sharp fraction. Depends on tfm_pkg.
`default_nettype none

module tfm_back #(
    parameter int MAX_WIDTH = tfm_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_restart,
    input  wire tfm_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_gray_valid,
    output logic                               o_gray_ready,
    input  wire logic [tfm_pkg::PIX_W-1:0]     i_gray,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic [tfm_pkg::OUT_CNT_W-1:0]      o_sharp_count,
    output logic [tfm_pkg::OUT_CNT_W-1:0]      o_pixel_total,
    output logic [tfm_pkg::FRAC_W-1:0]         o_sharp_fraction
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = tfm_pkg::DIM_W;
    localparam int TW = tfm_pkg::TOT_W;

    typedef enum logic [2:0] {S_RUN, S_SWEEP, S_DRAIN, S_DIV, S_OUT} t_state;

    typedef struct packed {
        logic                      sweep;
        logic                      first;
        logic                      main;
        logic                      at_end;
        logic                      left_far;
        logic [AW-1:0]             addr;
        logic [tfm_pkg::PIX_W-1:0] gray;
    } t_stage;

    t_state                    r_state;
    logic [DW-1:0]             r_col;
    logic [DW-1:0]             r_row;
    logic                      r_v1, r_v2, r_v3, r_v4;
    logic [TW-1:0]             r_count;
    logic [TW-1:0]             r_count_out;
    logic [TW:0]               r_rem;
    logic [tfm_pkg::FRAC_W-1:0] r_quot;
    logic [4:0]                r_iter;
    logic                      r_res_valid;
    logic [tfm_pkg::OUT_CNT_W-1:0] r_res_count;
    logic [tfm_pkg::FRAC_W-1:0]    r_res_frac;

    logic [tfm_pkg::PIX_W-1:0] r_upper  [MAX_WIDTH];
    logic [tfm_pkg::PIX_W-1:0] r_middle [MAX_WIDTH];
    logic [tfm_pkg::PIX_W-1:0] r_up_q;
    logic [tfm_pkg::PIX_W-1:0] r_mid_q;

    t_stage                    r_s1, r_s2;
    tfm_pkg::t_column          r_win0, r_win1, r_win2;
    logic                      r_main3, r_end3, r_main4, r_end4;
    logic signed [11:0]        r_gx, r_gy, r_gye;
    logic [20:0]               r_sqx, r_sqy, r_sqe;

    logic                      issue_run;
    logic                      issue_sweep;
    logic                      issue;
    logic                      last_col;
    logic                      res_free;
    t_stage                    n_s1;
    tfm_pkg::t_column          n_col;
    tfm_pkg::t_column          lc, cc, rc;
    logic signed [11:0]        t0, t1, t2, m0, m2, b0, b1, b2, et0, et1, eb0, eb1;
    logic signed [23:0]        px_sq, py_sq, pe_sq;
    logic [21:0]               energy;
    logic                      hit_main, hit_end;
    logic [TW:0]               div_t;
    logic                      div_bit;

    assign issue_run   = (r_state == S_RUN) && i_gray_valid;
    assign issue_sweep = (r_state == S_SWEEP);
    assign issue       = issue_run || issue_sweep;
    assign last_col    = r_col == (i_cfg.width - 12'd1);
    assign o_gray_ready = (r_state == S_RUN);
    assign res_free    = !r_res_valid || i_res_ready;

    always_comb begin
        n_s1.sweep    = issue_sweep;
        n_s1.first    = !issue_sweep && (r_row == 12'd1);
        n_s1.main     = (issue_sweep || r_row != '0) && (r_col != '0);
        n_s1.at_end   = (issue_sweep || r_row != '0) && last_col;
        n_s1.left_far = r_col >= 12'd2;
        n_s1.addr     = AW'(r_col);
        n_s1.gray     = i_gray;
    end

    // On the last-row sweep the row below the last one mirrors to row h-2.
    always_comb begin
        n_col.top = r_up_q;
        n_col.mid = r_mid_q;
        n_col.bot = r_s1.sweep ? r_up_q : r_s1.gray;
    end

    always_comb begin
        lc = r_s2.left_far ? r_win0 : r_win2;
        cc = r_win1;
        rc = r_win2;
        b0 = 12'(lc.bot);
        b1 = 12'(cc.bot);
        b2 = 12'(rc.bot);
        m0 = 12'(lc.mid);
        m2 = 12'(rc.mid);
        t0 = r_s2.first ? b0 : 12'(lc.top);
        t1 = r_s2.first ? b1 : 12'(cc.top);
        t2 = r_s2.first ? b2 : 12'(rc.top);
        // Right border: both neighbors are the column before, so gx is zero.
        eb0 = 12'(r_win1.bot);
        eb1 = 12'(r_win2.bot);
        et0 = r_s2.first ? eb0 : 12'(r_win1.top);
        et1 = r_s2.first ? eb1 : 12'(r_win2.top);
    end

    assign px_sq    = r_gx * r_gx;
    assign py_sq    = r_gy * r_gy;
    assign pe_sq    = r_gye * r_gye;
    assign energy   = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign hit_main = r_main4 && (energy > {1'b0, i_cfg.threshold});
    assign hit_end  = r_end4 && (r_sqe > i_cfg.threshold);

    assign div_t   = (r_iter == '0) ? r_rem : {r_rem[TW-1:0], 1'b0};
    assign div_bit = div_t >= {1'b0, i_cfg.total};

    // Line stores: read at issue, written next cycle from read data and gray.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_up_q  <= r_upper[n_s1.addr];
            r_mid_q <= r_middle[n_s1.addr];
        end
        if (r_v1 && !r_s1.sweep) begin
            r_upper[r_s1.addr]  <= r_mid_q;
            r_middle[r_s1.addr] <= r_s1.gray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1 <= n_s1;
        end
        if (r_v1) begin
            r_win0 <= r_win1;
            r_win1 <= r_win2;
            r_win2 <= n_col;
            r_s2   <= r_s1;
        end
        if (r_v2) begin
            r_gx    <= (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
            r_gy    <= (b0 + (b1 <<< 1) + b2) - (t0 + (t1 <<< 1) + t2);
            r_gye   <= ((eb0 <<< 1) + (eb1 <<< 1)) - ((et0 <<< 1) + (et1 <<< 1));
            r_main3 <= r_s2.main;
            r_end3  <= r_s2.at_end;
        end
        if (r_v3) begin
            r_sqx   <= px_sq[20:0];
            r_sqy   <= py_sq[20:0];
            r_sqe   <= pe_sq[20:0];
            r_main4 <= r_main3;
            r_end4  <= r_end3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state     <= S_RUN;
            r_col       <= '0;
            r_row       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (r_v4) begin
                r_count <= r_count + TW'(hit_main) + TW'(hit_end);
            end
            // The result register frees the back end while a result waits.
            if (r_state == S_OUT && res_free) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_RUN: begin
                    if (issue_run) begin
                        if (last_col) begin
                            r_col <= '0;
                            if (r_row == (i_cfg.height - 12'd1)) begin
                                r_row   <= '0;
                                r_state <= S_SWEEP;
                            end else begin
                                r_row <= r_row + 12'd1;
                            end
                        end else begin
                            r_col <= r_col + 12'd1;
                        end
                    end
                end
                S_SWEEP: begin
                    if (last_col) begin
                        r_col   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_col <= r_col + 12'd1;
                    end
                end
                S_DRAIN: begin
                    if (!(r_v1 || r_v2 || r_v3 || r_v4)) begin
                        r_rem       <= {1'b0, r_count};
                        r_count_out <= r_count;
                        r_count     <= '0;
                        r_quot      <= '0;
                        r_iter      <= '0;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_bit ? (div_t - {1'b0, i_cfg.total}) : div_t;
                    r_quot <= {r_quot[tfm_pkg::FRAC_W-2:0], div_bit};
                    r_iter <= r_iter + 5'd1;
                    if (r_iter == 5'(tfm_pkg::FRAC_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (res_free) begin
                        r_res_count <= r_count_out[tfm_pkg::OUT_CNT_W-1:0];
                        r_res_frac  <= r_quot;
                        r_state     <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_sharp_count    = r_res_count;
    assign o_pixel_total    = i_cfg.total[tfm_pkg::OUT_CNT_W-1:0];
    assign o_sharp_fraction = r_res_frac;

endmodule

`default_nettype wire

// File: rtl/tenengrad_focus_measure_unit.sv
// Tenengrad focus measure: throughput one pixel per cycle within a frame while
// the back end runs; after the last pixel the unit sweeps the last row, drains
// a 4-stage filter pipeline, runs a serial divider and loads the result when
// the result register is free, while pixels of the next frame wait in the queue.
// Synchronous active-low reset restores the register defaults and starts a frame;
// the line stores are not cleared.
`default_nettype none

module tenengrad_focus_measure_unit #(
    parameter int MAX_WIDTH  = tfm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tfm_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [tfm_pkg::PIX_W-1:0]       i_blue,
    input  wire logic [tfm_pkg::PIX_W-1:0]       i_green,
    input  wire logic [tfm_pkg::PIX_W-1:0]       i_red,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [tfm_pkg::OUT_CNT_W-1:0]        o_sharp_count,
    output logic [tfm_pkg::OUT_CNT_W-1:0]        o_pixel_total,
    output logic [tfm_pkg::FRAC_W-1:0]           o_sharp_fraction,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tfm_pkg::IDX_W-1:0]       i_cfg_index,
    input  wire logic [tfm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int DW = tfm_pkg::DIM_W;

    logic [DW-1:0]               r_width;
    logic [DW-1:0]               r_height;
    logic [tfm_pkg::THR_W-1:0]   r_threshold;
    logic                        r_color;
    logic [tfm_pkg::TOT_W-1:0]   r_total;
    logic [DW-1:0]               width_c;
    logic [DW-1:0]               height_c;
    logic                        cfg_write;
    logic                        restart;
    tfm_pkg::t_cfg               cfg;
    logic                        gray_valid, gray_ready, pop_valid, pop_ready;
    logic [tfm_pkg::PIX_W-1:0]   gray, pop_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_write && (i_cfg_index == tfm_pkg::REG_WIDTH
                      || i_cfg_index == tfm_pkg::REG_HEIGHT
                      || i_cfg_index == tfm_pkg::REG_THRESHOLD
                      || i_cfg_index == tfm_pkg::REG_COLOR);

    assign width_c  = (r_width < tfm_pkg::MIN_DIM) ? tfm_pkg::MIN_DIM
                    : ((32'(r_width) > MAX_WIDTH) ? DW'(MAX_WIDTH) : r_width);
    assign height_c = (r_height < tfm_pkg::MIN_DIM) ? tfm_pkg::MIN_DIM
                    : ((32'(r_height) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : r_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= tfm_pkg::RST_WIDTH;
            r_height    <= tfm_pkg::RST_HEIGHT;
            r_threshold <= tfm_pkg::RST_THRESHOLD;
            r_color     <= tfm_pkg::RST_COLOR;
        end else if (cfg_write) begin
            case (i_cfg_index)
                tfm_pkg::REG_WIDTH:     r_width     <= i_cfg_data[DW-1:0];
                tfm_pkg::REG_HEIGHT:    r_height    <= i_cfg_data[DW-1:0];
                tfm_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                tfm_pkg::REG_COLOR:     r_color     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= width_c * height_c;
    end

    always_comb begin
        cfg.width     = width_c;
        cfg.height    = height_c;
        cfg.threshold = r_threshold;
        cfg.total     = r_total;
        cfg.color     = r_color;
    end

    tfm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .o_gray_valid (gray_valid),
        .i_gray_ready (gray_ready),
        .o_gray       (gray)
    );

    tfm_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (gray_valid),
        .o_push_ready (gray_ready),
        .i_push_data  (gray),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    tfm_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_restart        (restart),
        .i_cfg            (cfg),
        .i_gray_valid     (pop_valid),
        .o_gray_ready     (pop_ready),
        .i_gray           (pop_data),
        .o_res_valid      (o_out_valid),
        .i_res_ready      (i_out_ready),
        .o_sharp_count    (o_sharp_count),
        .o_pixel_total    (o_pixel_total),
        .o_sharp_fraction (o_sharp_fraction)
    );

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sharp_fraction <= 17'd65536)
        else $error("sharp fraction above one");

    a_count_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sharp_count <= o_pixel_total)
        else $error("sharp count exceeds pixel total");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> !o_out_valid)
        else $error("result still pending after register write");

endmodule

`default_nettype wire

// File: dv/tenengrad_focus_checker.sv
// Checker for the Tenengrad focus measure unit: watches the pixel, result and register
// channels, predicts each frame result and compares it field by field.
// Depends on tfm_pkg for widths, register indexes and the column type.
`timescale 1ns / 1ps

module tenengrad_focus_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic [tfm_pkg::PIX_W-1:0]      i_blue,
    input  wire logic [tfm_pkg::PIX_W-1:0]      i_green,
    input  wire logic [tfm_pkg::PIX_W-1:0]      i_red,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [tfm_pkg::OUT_CNT_W-1:0]  i_sharp_count,
    input  wire logic [tfm_pkg::OUT_CNT_W-1:0]  i_pixel_total,
    input  wire logic [tfm_pkg::FRAC_W-1:0]     i_sharp_fraction,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [tfm_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire logic [tfm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct {
        logic [tfm_pkg::OUT_CNT_W-1:0] sharp_count;
        logic [tfm_pkg::OUT_CNT_W-1:0] pixel_total;
        logic [tfm_pkg::FRAC_W-1:0]    sharp_fraction;
    } t_frame_score;

    t_frame_score score_queue[$];

    logic [tfm_pkg::PIX_W-1:0] prev_row_mem[tfm_pkg::DEF_MAX_WIDTH];
    logic [tfm_pkg::PIX_W-1:0] cur_row_mem[tfm_pkg::DEF_MAX_WIDTH];
    tfm_pkg::t_column          win_col[3];
    int unsigned               col_pos;
    int unsigned               row_pos;
    int unsigned               sharp_tally;

    logic [tfm_pkg::DIM_W-1:0] cfg_width;
    logic [tfm_pkg::DIM_W-1:0] cfg_height;
    logic [tfm_pkg::THR_W-1:0] cfg_threshold;
    logic                      cfg_color;

    initial begin
        o_fail_count = 0;
        foreach (prev_row_mem[k]) begin
            prev_row_mem[k] = '0;
            cur_row_mem[k]  = '0;
        end
    end

    assign o_pending = score_queue.size();

    function automatic int unsigned clamp_dim(logic [tfm_pkg::DIM_W-1:0] d,
                                              int unsigned maxv);
        if (d < tfm_pkg::MIN_DIM) return 3;
        if (d > maxv) return maxv;
        return d;
    endfunction

    function automatic tfm_pkg::t_column make_col(logic [tfm_pkg::PIX_W-1:0] t,
                                                  logic [tfm_pkg::PIX_W-1:0] m,
                                                  logic [tfm_pkg::PIX_W-1:0] b);
        tfm_pkg::t_column c;
        c.top = t;
        c.mid = m;
        c.bot = b;
        return c;
    endfunction

    task automatic restart_frame();
        foreach (win_col[k]) win_col[k] = '0;
        col_pos     = 0;
        row_pos     = 0;
        sharp_tally = 0;
    endtask

    // The first row has no row above, so the top mirrors the bottom.
    task automatic grade_window(tfm_pkg::t_column l, tfm_pkg::t_column c,
                                tfm_pkg::t_column r, bit mirror_top);
        int t0, t1, t2, m0, m2, b0, b1, b2, gx, gy;
        longint energy;
        t0 = l.top; t1 = c.top; t2 = r.top;
        m0 = l.mid; m2 = r.mid;
        b0 = l.bot; b1 = c.bot; b2 = r.bot;
        if (mirror_top) begin
            t0 = b0; t1 = b1; t2 = b2;
        end
        gx = (t2 - t0) + 2 * (m2 - m0) + (b2 - b0);
        gy = (b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2);
        energy = longint'(gx * gx) + longint'(gy * gy);
        if (energy > cfg_threshold) sharp_tally++;
    endtask

    task automatic take_pixel(logic [tfm_pkg::PIX_W-1:0] b, logic [tfm_pkg::PIX_W-1:0] g,
                              logic [tfm_pkg::PIX_W-1:0] r);
        int unsigned w, h, xl, xr, gray;
        longint unsigned total, num;
        t_frame_score s;
        w = clamp_dim(cfg_width, tfm_pkg::DEF_MAX_WIDTH);
        h = clamp_dim(cfg_height, tfm_pkg::DEF_MAX_HEIGHT);
        if (col_pos >= w || row_pos >= h) restart_frame();
        if (cfg_color)
            gray = (tfm_pkg::W_BLUE * b + tfm_pkg::W_GREEN * g + tfm_pkg::W_RED * r
                    + tfm_pkg::W_ROUND) >> 14;
        else gray = g;
        gray &= 8'hFF;
        win_col[0] = win_col[1];
        win_col[1] = win_col[2];
        win_col[2] = make_col(prev_row_mem[col_pos], cur_row_mem[col_pos], gray[7:0]);
        prev_row_mem[col_pos] = cur_row_mem[col_pos];
        cur_row_mem[col_pos]  = gray[7:0];
        if (row_pos >= 1) begin
            if (col_pos >= 1)
                grade_window(col_pos >= 2 ? win_col[0] : win_col[2], win_col[1], win_col[2],
                             row_pos == 1);
            if (col_pos == w - 1)
                grade_window(win_col[1], win_col[2], win_col[1], row_pos == 1);
        end
        col_pos++;
        if (col_pos < w) return;
        col_pos = 0;
        row_pos++;
        if (row_pos < h) return;
        // Last row: the rows above and below are both the row before it.
        for (int x = 0; x < w; x++) begin
            xl = (x == 0) ? 1 : x - 1;
            xr = (x == w - 1) ? w - 2 : x + 1;
            grade_window(make_col(prev_row_mem[xl], cur_row_mem[xl], prev_row_mem[xl]),
                         make_col(prev_row_mem[x], cur_row_mem[x], prev_row_mem[x]),
                         make_col(prev_row_mem[xr], cur_row_mem[xr], prev_row_mem[xr]), 1'b0);
        end
        total = longint'(w) * h;
        num   = longint'(sharp_tally) << 16;
        s.sharp_count    = sharp_tally[tfm_pkg::OUT_CNT_W-1:0];
        s.pixel_total    = total[tfm_pkg::OUT_CNT_W-1:0];
        s.sharp_fraction = 17'(num / total);
        score_queue.push_back(s);
        restart_frame();
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_frame_score want;
        if (!i_rst_n) begin
            cfg_width     = tfm_pkg::RST_WIDTH;
            cfg_height    = tfm_pkg::RST_HEIGHT;
            cfg_threshold = tfm_pkg::RST_THRESHOLD;
            cfg_color     = tfm_pkg::RST_COLOR;
            restart_frame();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (score_queue.size() == 0) begin
                    report_mismatch("unexpected result transaction", i_sharp_count, -1);
                end else begin
                    want = score_queue.pop_front();
                    if (i_sharp_count !== want.sharp_count)
                        report_mismatch("sharp_count", i_sharp_count, want.sharp_count);
                    if (i_pixel_total !== want.pixel_total)
                        report_mismatch("pixel_total", i_pixel_total, want.pixel_total);
                    if (i_sharp_fraction !== want.sharp_fraction)
                        report_mismatch("sharp_fraction", i_sharp_fraction,
                                        want.sharp_fraction);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tfm_pkg::REG_WIDTH: begin
                        cfg_width = i_cfg_data[tfm_pkg::DIM_W-1:0];
                        restart_frame();
                    end
                    tfm_pkg::REG_HEIGHT: begin
                        cfg_height = i_cfg_data[tfm_pkg::DIM_W-1:0];
                        restart_frame();
                    end
                    tfm_pkg::REG_THRESHOLD: begin
                        cfg_threshold = i_cfg_data[tfm_pkg::THR_W-1:0];
                        restart_frame();
                    end
                    tfm_pkg::REG_COLOR: begin
                        cfg_color = i_cfg_data[0];
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) take_pixel(i_blue, i_green, i_red);
        end
    end

endmodule

// File: dv/testbench.sv
// Top of the focus measure testbench: clock, reset, pixel and register stimulus,
// receiver stalls, watchdog and verdict. Depends on tfm_pkg, the unit and the checker.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_TARGET = 765;
    localparam logic [tfm_pkg::IDX_W-1:0] REG_UNUSED_LOW  = 8'd4;
    localparam logic [tfm_pkg::IDX_W-1:0] REG_UNUSED_HIGH = 8'd255;

    typedef enum int { PAT_NOISE, PAT_CHECKER, PAT_FLAT, PAT_EDGE } t_pattern;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic [tfm_pkg::PIX_W-1:0]      blue = '0;
    logic [tfm_pkg::PIX_W-1:0]      green = '0;
    logic [tfm_pkg::PIX_W-1:0]      red = '0;
    logic                           out_ready = 1'b1;
    logic                           cfg_valid = 1'b0;
    logic [tfm_pkg::IDX_W-1:0]      cfg_index = '0;
    logic [tfm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    wire                            in_ready, out_valid, cfg_ready;
    wire [tfm_pkg::OUT_CNT_W-1:0]   sharp_count, pixel_total;
    wire [tfm_pkg::FRAC_W-1:0]      sharp_fraction;
    int                             fail_count, pending;

    int unsigned cur_w = 640, cur_h = 480;
    int          burst_left = 0;
    bit          tx_gaps = 1'b0;
    int          rx_mode = 0;
    int          rx_hold = 0;
    int          idle_cycles = 0;
    int          random_pixels = 0;

    always #10 i_clk = ~i_clk;

    tenengrad_focus_measure_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_blue(blue), .i_green(green), .i_red(red),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_sharp_count(sharp_count), .o_pixel_total(pixel_total),
        .o_sharp_fraction(sharp_fraction),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    tenengrad_focus_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_blue(blue), .i_green(green), .i_red(red),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_sharp_count(sharp_count), .i_pixel_total(pixel_total),
        .i_sharp_fraction(sharp_fraction),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: always ready, random stalls, or stall stretches of random length.
    always @(negedge i_clk) begin
        if (rx_mode == 0) begin
            out_ready <= 1'b1;
        end else if (rx_mode == 1) begin
            out_ready <= ($urandom_range(0, 2) != 0);
        end else if (rx_hold > 0) begin
            rx_hold--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 30);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(logic [tfm_pkg::DIM_W-1:0] d);
        if (d < tfm_pkg::MIN_DIM) return 3;
        if (d > tfm_pkg::DEF_MAX_WIDTH) return tfm_pkg::DEF_MAX_WIDTH;
        return d;
    endfunction

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [tfm_pkg::IDX_W-1:0] idx,
                             logic [tfm_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        if (idx == tfm_pkg::REG_WIDTH) cur_w = clamp_dim(data[tfm_pkg::DIM_W-1:0]);
        if (idx == tfm_pkg::REG_HEIGHT) cur_h = clamp_dim(data[tfm_pkg::DIM_W-1:0]);
    endtask

    task automatic send_pixel(logic [tfm_pkg::PIX_W-1:0] b, logic [tfm_pkg::PIX_W-1:0] g,
                              logic [tfm_pkg::PIX_W-1:0] r);
        int gap;
        if (tx_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        blue  = b;
        green = g;
        red   = r;
        do @(posedge i_clk); while (!in_ready);
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_frame(t_pattern pat, int unsigned count);
        int unsigned x, y, base;
        logic [tfm_pkg::PIX_W-1:0] v;
        base = $urandom_range(0, 250);
        for (int unsigned n = 0; n < count; n++) begin
            x = n % cur_w;
            y = n / cur_w;
            case (pat)
                PAT_CHECKER: v = ((x + y) % 2) ? 8'hFF : 8'h00;
                PAT_FLAT:    v = 8'(base + $urandom_range(0, 5));
                PAT_EDGE:    v = (x < cur_w / 2) ? base[7:0] : ~base[7:0];
                default:     v = 8'($urandom);
            endcase
            if (pat == PAT_NOISE) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            else send_pixel(v, v, v);
        end
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic full_frame(t_pattern pat);
        send_frame(pat, cur_w * cur_h);
    endtask

    initial begin
        int unsigned cut;
        t_pattern pat;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Register defaults after reset: the start of a frame without gaps.
        send_frame(PAT_NOISE, 100);
        wait_drained();

        tx_gaps = 1'b1;
        rx_mode = 1;
        write_reg(tfm_pkg::REG_WIDTH, 21'h1FF003);
        write_reg(tfm_pkg::REG_HEIGHT, 21'h1FF003);
        write_reg(tfm_pkg::REG_THRESHOLD, 21'd0);
        write_reg(tfm_pkg::REG_COLOR, 21'h1FFFFE);
        full_frame(PAT_CHECKER);
        full_frame(PAT_FLAT);
        full_frame(PAT_NOISE);
        wait_drained();
        write_reg(tfm_pkg::REG_COLOR, 21'd1);
        write_reg(tfm_pkg::REG_THRESHOLD, 21'h1FFFFF);
        full_frame(PAT_CHECKER);
        wait_drained();
        write_reg(tfm_pkg::REG_COLOR, 21'd0);
        write_reg(tfm_pkg::REG_THRESHOLD, 21'd2080800);
        full_frame(PAT_CHECKER);
        full_frame(PAT_EDGE);
        wait_drained();
        // Dimensions below the minimum and above the maximum are clamped.
        write_reg(tfm_pkg::REG_WIDTH, 21'd0);
        write_reg(tfm_pkg::REG_HEIGHT, 21'd1);
        write_reg(tfm_pkg::REG_THRESHOLD, 21'd500);
        full_frame(PAT_EDGE);
        wait_drained();
        rx_mode = 2;
        write_reg(tfm_pkg::REG_WIDTH, 21'hFFF);
        write_reg(tfm_pkg::REG_HEIGHT, 21'd2);
        send_frame(PAT_NOISE, 40);
        wait_drained();
        write_reg(tfm_pkg::REG_WIDTH, 21'd2);
        write_reg(tfm_pkg::REG_HEIGHT, 21'hFFF);
        send_frame(PAT_EDGE, 40);
        wait_drained();
        // Writes to unused indexes must leave the registers alone.
        write_reg(tfm_pkg::REG_WIDTH, 21'd5);
        write_reg(tfm_pkg::REG_HEIGHT, 21'd4);
        write_reg(REG_UNUSED_LOW, 21'h1FFFFF);
        write_reg(REG_UNUSED_HIGH, 21'd3);
        full_frame(PAT_NOISE);
        wait_drained();
        // A register write in the middle of a frame starts a new frame.
        send_frame(PAT_NOISE, 7);
        wait_drained();
        write_reg(tfm_pkg::REG_HEIGHT, 21'd3);
        full_frame(PAT_NOISE);
        wait_drained();

        while (random_pixels < RANDOM_TARGET) begin
            rx_mode = $urandom_range(0, 2);
            tx_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
                write_reg(tfm_pkg::REG_WIDTH, 21'($urandom_range(3, 10)));
            if ($urandom_range(0, 1))
                write_reg(tfm_pkg::REG_HEIGHT, 21'($urandom_range(3, 8)));
            case ($urandom_range(0, 3))
                0: write_reg(tfm_pkg::REG_THRESHOLD, 21'($urandom_range(0, 3000)));
                1: write_reg(tfm_pkg::REG_THRESHOLD, 21'($urandom_range(0, 2080800)));
                2: write_reg(tfm_pkg::REG_THRESHOLD, 21'($urandom_range(0, 40000)));
                default: ;
            endcase
            if ($urandom_range(0, 1)) write_reg(tfm_pkg::REG_COLOR, 21'($urandom));
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, cur_w * cur_h - 1);
                send_frame(PAT_NOISE, cut);
                random_pixels += cut;
                wait_drained();
                write_reg(tfm_pkg::REG_COLOR, 21'($urandom));
            end
            repeat ($urandom_range(1, 4)) begin
                pat = t_pattern'($urandom_range(0, 3));
                full_frame(pat);
                random_pixels += cur_w * cur_h;
            end
            wait_drained();
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/tfm_pkg.sv
rtl/tfm_front.sv
rtl/tfm_fifo.sv
rtl/tfm_back.sv
rtl/tenengrad_focus_measure_unit.sv
dv/tenengrad_focus_checker.sv
dv/testbench.sv
